### src/clock_date_time_setter_assert.svh
// assertion macros shared by the clock date and time setter
`ifndef CLOCK_DATE_TIME_SETTER_ASSERT_SVH
`define CLOCK_DATE_TIME_SETTER_ASSERT_SVH

// checked only while out of reset
`define CDTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge
`define CDTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/cdts_pkg.sv
// types, codes and helper functions of the clock date and time setter
package cdts_pkg;

  typedef enum logic [1:0] {
    OP_MODE = 2'd0,
    OP_DOWN = 2'd1,
    OP_UP   = 2'd2
  } cdts_op_t;

  // field codes shared by the cursor and the edit target
  localparam logic [2:0] FLD_NONE   = 3'd0;
  localparam logic [2:0] FLD_YEAR   = 3'd1;
  localparam logic [2:0] FLD_MONTH  = 3'd2;
  localparam logic [2:0] FLD_DAY    = 3'd3;
  localparam logic [2:0] FLD_HOUR   = 3'd4;
  localparam logic [2:0] FLD_MINUTE = 3'd5;
  localparam logic [2:0] FLD_SECOND = 3'd6;
  localparam logic [2:0] CURSOR_WRAP = 3'd7;

  localparam logic [12:0] YEAR_MIN = 13'd1970;
  localparam logic [12:0] YEAR_MAX = 13'd2099;

  localparam logic [5:0] MONTH_FIRST = 6'd1;
  localparam logic [5:0] MONTH_LAST  = 6'd12;
  localparam logic [5:0] DAY_FIRST   = 6'd1;
  localparam logic [5:0] HOUR_LAST   = 6'd23;
  localparam logic [5:0] MINSEC_LAST = 6'd59;
  localparam logic [5:0] ZERO_VAL    = 6'd0;

  localparam logic [4:0] DAYS_LONG  = 5'd31;
  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_LEAP  = 5'd29;
  localparam logic [4:0] DAYS_FEB   = 5'd28;

  // reciprocal of 100 scaled by 2^19, exact for 12-bit years
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam logic [6:0]  CENTURY   = 7'd100;

  typedef struct packed {
    logic [1:0]  operation;
    logic        key_confirmed;
    logic [11:0] current_year;
    logic [3:0]  current_month;
    logic [4:0]  current_day;
    logic [4:0]  current_hour;
    logic [5:0]  current_minute;
    logic [5:0]  current_second;
  } cdts_item_t;

  typedef struct packed {
    logic [11:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [5:0]  new_second;
    logic [2:0]  cursor_position;
    logic [2:0]  field_in_edit;
    logic        write_clock;
  } cdts_result_t;

  typedef struct packed {
    logic [2:0] cursor;
    logic [2:0] edit_target;
  } cdts_state_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = DAYS_LONG;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = DAYS_SHORT;
      4'd2:                    len = leap ? DAYS_LEAP : DAYS_FEB;
      default:                 len = DAYS_LONG;
    endcase
    return len;
  endfunction

  // step over lo..hi with wrap; out-of-range values land on hi (down) or lo (up)
  function automatic logic [5:0] wrap_step(input logic [5:0] v, input logic [5:0] lo,
                                           input logic [5:0] hi, input logic up);
    logic [5:0] res;
    if (up) begin
      res = (v >= lo && v < hi) ? v + 6'd1 : lo;
    end else begin
      res = (v > lo && v <= hi) ? v - 6'd1 : hi;
    end
    return res;
  endfunction

endpackage

### src/clock_date_time_setter.sv
// top level of the clock date and time setter: input register, update, result register
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | key operation and current date and time
//   out_    | output    | out_valid / out_ready| new date and time, cursor, edit field, write
//
// one item per cycle unless out_ready stalls; results leave from the result register
// the update is combinational between the input register and the result register
// while the result waits, one more item is held in the input register
// reset clears both valid flags, the cursor and the edit target
module clock_date_time_setter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic        in_key_confirmed,
  input  logic [11:0] in_current_year,
  input  logic [3:0]  in_current_month,
  input  logic [4:0]  in_current_day,
  input  logic [4:0]  in_current_hour,
  input  logic [5:0]  in_current_minute,
  input  logic [5:0]  in_current_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_new_year,
  output logic [3:0]  out_new_month,
  output logic [4:0]  out_new_day,
  output logic [4:0]  out_new_hour,
  output logic [5:0]  out_new_minute,
  output logic [5:0]  out_new_second,
  output logic [2:0]  out_cursor_position,
  output logic [2:0]  out_field_in_edit,
  output logic        out_write_clock
);
  import cdts_pkg::*;

  cdts_item_t   item_r;
  logic         item_valid_r;
  cdts_state_t  st_r;
  cdts_state_t  st_nxt;
  cdts_result_t res_nxt;
  cdts_result_t res_r;
  logic         res_valid_r;
  logic         advance;

  // item moves on when the result register is free or being emptied
  assign advance  = item_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  cdts_update u_update (
    .item   (item_r),
    .st     (st_r),
    .res    (res_nxt),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
      st_r         <= '0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{operation:      in_operation,
                  key_confirmed:  in_key_confirmed,
                  current_year:   in_current_year,
                  current_month:  in_current_month,
                  current_day:    in_current_day,
                  current_hour:   in_current_hour,
                  current_minute: in_current_minute,
                  current_second: in_current_second};
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = res_valid_r;
  assign out_new_year        = res_r.new_year;
  assign out_new_month       = res_r.new_month;
  assign out_new_day         = res_r.new_day;
  assign out_new_hour        = res_r.new_hour;
  assign out_new_minute      = res_r.new_minute;
  assign out_new_second      = res_r.new_second;
  assign out_cursor_position = res_r.cursor_position;
  assign out_field_in_edit   = res_r.field_in_edit;
  assign out_write_clock     = res_r.write_clock;

`include "clock_date_time_setter_assert.svh"

  `CDTS_ASSERT(a_cursor_range, st_r.cursor != CURSOR_WRAP, "cursor reached the wrap code")
  `CDTS_ASSERT(a_edit_kept, st_r.edit_target != FLD_NONE |=> st_r.edit_target != FLD_NONE, "edit target cleared")
  `CDTS_ASSERT(a_write_needs_target, out_valid && out_write_clock |-> out_field_in_edit != FLD_NONE, "clock write with no edit field")
  `CDTS_ASSERT(a_cursor_is_target, out_valid && out_cursor_position != FLD_NONE |-> out_field_in_edit == out_cursor_position, "edit field differs from cursor")

endmodule

### src/cdts_update.sv
// next date, time, cursor and edit target for one key item
module cdts_update (
  input  cdts_pkg::cdts_item_t   item,
  input  cdts_pkg::cdts_state_t  st,
  output cdts_pkg::cdts_result_t res,
  output cdts_pkg::cdts_state_t  st_nxt
);
  import cdts_pkg::*;

  logic [24:0] year_prod;
  logic [5:0]  year_q;
  logic [11:0] year_rem;
  logic        leap;
  logic [4:0]  days;
  logic        up;
  logic [12:0] year_step;
  logic [12:0] year_adj;
  logic [2:0]  cursor_inc;
  logic [5:0]  day_wrap;

  // leap test: divisible by 4, and not a century unless the century count is too
  assign year_prod = {13'd0, item.current_year} * {12'd0, RECIP_100};
  assign year_q    = year_prod[24:19];
  assign year_rem  = item.current_year - 12'({6'd0, year_q} * {5'd0, CENTURY});
  assign leap      = (item.current_year[1:0] == 2'd0) &&
                     ((year_rem != 12'd0) || (year_q[1:0] == 2'd0));
  assign days      = month_len(item.current_month, leap);

  assign up = (item.operation == OP_UP);

  always_comb begin
    if (up) begin
      year_step = {1'b0, item.current_year} + 13'd1;
    end else if (item.current_year == 12'd0) begin
      year_step = 13'd0;
    end else begin
      year_step = {1'b0, item.current_year} - 13'd1;
    end
    if (year_step < YEAR_MIN) begin
      year_adj = YEAR_MIN;
    end else if (year_step > YEAR_MAX) begin
      year_adj = YEAR_MAX;
    end else begin
      year_adj = year_step;
    end
  end

  assign cursor_inc = st.cursor + 3'd1;
  assign day_wrap   = wrap_step({1'b0, item.current_day}, DAY_FIRST, {1'b0, days}, up);

  always_comb begin
    st_nxt              = st;
    res.new_year        = item.current_year;
    res.new_month       = item.current_month;
    res.new_day         = item.current_day;
    res.new_hour        = item.current_hour;
    res.new_minute      = item.current_minute;
    res.new_second      = item.current_second;
    res.write_clock     = 1'b0;
    if (item.key_confirmed) begin
      unique case (item.operation)
        OP_MODE: begin
          st_nxt.cursor = (cursor_inc == CURSOR_WRAP) ? FLD_NONE : cursor_inc;
          if (st_nxt.cursor != FLD_NONE) begin
            st_nxt.edit_target = st_nxt.cursor;
          end
        end
        OP_DOWN, OP_UP: begin
          res.write_clock = 1'b1;
          unique case (st.edit_target)
            FLD_YEAR:   res.new_year = year_adj[11:0];
            FLD_MONTH:  res.new_month =
                          4'(wrap_step({2'd0, item.current_month}, MONTH_FIRST, MONTH_LAST, up));
            FLD_DAY:    res.new_day = day_wrap[4:0];
            FLD_HOUR:   res.new_hour =
                          5'(wrap_step({1'b0, item.current_hour}, ZERO_VAL, HOUR_LAST, up));
            FLD_MINUTE: res.new_minute =
                          wrap_step(item.current_minute, ZERO_VAL, MINSEC_LAST, up);
            FLD_SECOND: res.new_second =
                          wrap_step(item.current_second, ZERO_VAL, MINSEC_LAST, up);
            default:    res.write_clock = 1'b0;
          endcase
        end
        default: ;
      endcase
    end
    res.cursor_position = st_nxt.cursor;
    res.field_in_edit   = st_nxt.edit_target;
  end

endmodule
